// ===== sv/rfs_pkg.sv =====
// Shared types and constants of the roulette fitness selector.
// Used by every module of the block but the RAM; depends on nothing.
`timescale 1ns / 1ps

package rfs_pkg;

  // Table geometry and field widths
  localparam int MAX_POPULATION = 256;
  localparam int FITNESS_BITS   = 32;
  localparam int TOTAL_BITS     = 40;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_POP_BITS   = 9;
  localparam int IDX_BITS       = $clog2(MAX_POPULATION);
  localparam int POP_BITS       = $clog2(MAX_POPULATION + 1);
  localparam int SLICE_BITS     = TOTAL_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS   = $clog2(TOTAL_BITS);

  // Register index of population_size on the configuration port
  localparam logic REG_POP = 1'b0;

  // Result kinds
  localparam logic KIND_STATS  = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_STATS  = 2'd1,
    OP_SELECT = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STAT_WALK,
    ST_STAT_LAST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SEL_MUL,
    ST_SEL_WALK,
    ST_SEL_LAST,
    ST_SEL_OUT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ram_we;
    logic clr_stats;
    logic clr_sel;
    logic mul;
    logic issue;
    logic sel_mode;
    logic div_start;
    logic emit_stats;
    logic emit_sel;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_issue;
    logic div_done;
  } status_t;

endpackage

// ===== sv/rfs_ram.sv =====
// Generic single-port RAM with registered read data.
// Stand-alone; used by the datapath for the fitness table.
`timescale 1ns / 1ps

module rfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on we, read the addressed word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rfs_div.sv =====
// Restoring divider: one quotient bit per cycle, total by walk length.
// Depends on rfs_pkg for widths.
`timescale 1ns / 1ps

module rfs_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rfs_pkg::TOTAL_BITS-1:0] dividend_i,
  input  logic [rfs_pkg::POP_BITS-1:0]   divisor_i,
  output logic                           done_o,
  output logic [rfs_pkg::TOTAL_BITS-1:0] quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [rfs_pkg::DIV_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [rfs_pkg::TOTAL_BITS-1:0]    quo_q, quo_d;
  logic [rfs_pkg::POP_BITS-1:0]      rem_q, rem_d;
  logic [rfs_pkg::POP_BITS-1:0]      dvs_q, dvs_d;
  logic [rfs_pkg::POP_BITS:0]        trial;
  logic                              fits;

  // Shift in the next dividend bit and subtract when the divisor fits
  always_comb begin
    trial  = {rem_q, quo_q[rfs_pkg::TOTAL_BITS-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rfs_pkg::DIV_CNT_BITS'(rfs_pkg::TOTAL_BITS - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[rfs_pkg::TOTAL_BITS-2:0], fits};
      rem_d = fits ? rfs_pkg::POP_BITS'(trial - {1'b0, dvs_q})
                   : rfs_pkg::POP_BITS'(trial);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Done is a single pulse after the last step
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still stepping");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not start");

endmodule

// ===== sv/rfs_ctrl.sv =====
// Controller state machine: sequences writes, statistics walks and selections.
// Depends on rfs_pkg for states, opcodes, command and status types.
`timescale 1ns / 1ps

module rfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       opcode_i,
  input  rfs_pkg::status_t status_i,
  output rfs_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  rfs_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rfs_pkg::ST_IDLE: begin
        if (start_i) begin
          case (opcode_i)
            rfs_pkg::OP_WRITE: begin
              cmd_o.ram_we = 1'b1;
            end
            rfs_pkg::OP_STATS: begin
              cmd_o.clr_stats = 1'b1;
              state_d         = rfs_pkg::ST_STAT_WALK;
            end
            rfs_pkg::OP_SELECT: begin
              cmd_o.clr_sel = 1'b1;
              state_d       = rfs_pkg::ST_SEL_MUL;
            end
            default: begin
              state_d = rfs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rfs_pkg::ST_STAT_WALK: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = rfs_pkg::ST_STAT_LAST;
        end
      end
      rfs_pkg::ST_STAT_LAST: begin
        state_d = rfs_pkg::ST_DIV_START;
      end
      rfs_pkg::ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = rfs_pkg::ST_DIV_WAIT;
      end
      rfs_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.emit_stats = 1'b1;
          state_d          = rfs_pkg::ST_IDLE;
        end
      end
      rfs_pkg::ST_SEL_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = rfs_pkg::ST_SEL_WALK;
      end
      rfs_pkg::ST_SEL_WALK: begin
        cmd_o.issue    = 1'b1;
        cmd_o.sel_mode = 1'b1;
        if (status_i.last_issue) begin
          state_d = rfs_pkg::ST_SEL_LAST;
        end
      end
      rfs_pkg::ST_SEL_LAST: begin
        state_d = rfs_pkg::ST_SEL_OUT;
      end
      rfs_pkg::ST_SEL_OUT: begin
        cmd_o.emit_sel = 1'b1;
        state_d        = rfs_pkg::ST_IDLE;
      end
      default: begin
        state_d = rfs_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != rfs_pkg::ST_IDLE);

  // A statistics walk ends only through its drain state
  a_walk_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rfs_pkg::ST_STAT_WALK && state_d != rfs_pkg::ST_STAT_WALK)
    |-> status_i.last_issue)
    else $error("statistics walk left early");

endmodule

// ===== sv/rfs_dp.sv =====
// Datapath: fitness table, walk counter, statistics, wheel compare, results.
// Depends on rfs_pkg, rfs_ram and rfs_div.
`timescale 1ns / 1ps

module rfs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rfs_pkg::cmd_t                    cmd_i,
  output rfs_pkg::status_t                 status_o,
  input  logic [rfs_pkg::CFG_POP_BITS-1:0] pop_i,
  input  logic [7:0]                       entry_index_i,
  input  logic [31:0]                      fitness_value_i,
  input  logic [15:0]                      random_fraction_i,
  output logic                             result_strobe_o,
  output logic                             result_kind_o,
  output logic [7:0]                       selected_index_o,
  output logic [7:0]                       fittest_index_o,
  output logic [31:0]                      best_fitness_o,
  output logic [31:0]                      worst_fitness_o,
  output logic [39:0]                      total_fitness_o,
  output logic [31:0]                      average_fitness_o
);

  logic [rfs_pkg::POP_BITS-1:0]     walk_n, walk_last;
  logic [rfs_pkg::IDX_BITS-1:0]     cnt_q, rd_idx_q, ram_addr;
  logic                             rd_vld_q, rd_sel_q;
  logic                             ram_we;
  logic [rfs_pkg::FITNESS_BITS-1:0] rd_data;
  logic [rfs_pkg::FITNESS_BITS-1:0] best_q, worst_q;
  logic [rfs_pkg::TOTAL_BITS-1:0]   total_q, sum_q, sum_nx;
  logic [rfs_pkg::IDX_BITS-1:0]     fidx_q, chosen_q;
  logic                             found_q, hit;
  logic [rfs_pkg::FRAC_BITS-1:0]    frac_q;
  logic [rfs_pkg::SLICE_BITS-1:0]   slice_q;
  logic                             div_done;
  logic [rfs_pkg::TOTAL_BITS-1:0]   quotient;
  logic                             strobe_q;
  logic                             kind_q;
  logic [7:0]                       sel_idx_q, fit_idx_q;
  logic [31:0]                      best_out_q, worst_out_q, avg_out_q;
  logic [39:0]                      total_out_q;

  // Clamp the register to a legal walk length
  always_comb begin
    if (pop_i == '0) begin
      walk_n = rfs_pkg::POP_BITS'(1);
    end else if (32'(pop_i) > rfs_pkg::MAX_POPULATION) begin
      walk_n = rfs_pkg::POP_BITS'(rfs_pkg::MAX_POPULATION);
    end else begin
      walk_n = rfs_pkg::POP_BITS'(pop_i);
    end
    walk_last = walk_n - 1'b1;
  end

  assign status_o.last_issue = (rfs_pkg::POP_BITS'(cnt_q) == walk_last);
  assign status_o.div_done   = div_done;

  // Table port: writes at accept, walk reads otherwise
  assign ram_we   = cmd_i.ram_we && (32'(entry_index_i) < rfs_pkg::MAX_POPULATION);
  assign ram_addr = cmd_i.ram_we ? rfs_pkg::IDX_BITS'(entry_index_i) : cnt_q;

  rfs_ram #(
    .WIDTH(rfs_pkg::FITNESS_BITS),
    .DEPTH(rfs_pkg::MAX_POPULATION)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(rfs_pkg::FITNESS_BITS'(fitness_value_i)),
    .rdata_o(rd_data)
  );

  // Wheel compare on the running sum including the arriving entry
  assign sum_nx = sum_q + rfs_pkg::TOTAL_BITS'(rd_data);
  assign hit    = {sum_nx, rfs_pkg::FRAC_BITS'(0)} >= slice_q;

  // Walk control and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_sel_q <= 1'b0;
      total_q  <= '0;
      fidx_q   <= '0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      rd_sel_q <= cmd_i.sel_mode;
      strobe_q <= cmd_i.emit_stats || cmd_i.emit_sel;
      if (cmd_i.clr_stats || cmd_i.clr_sel) begin
        cnt_q <= '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.clr_stats) begin
        total_q <= '0;
      end else if (rd_vld_q && !rd_sel_q) begin
        total_q <= total_q + rfs_pkg::TOTAL_BITS'(rd_data);
        if (rd_data > best_q) begin
          fidx_q <= rd_idx_q;
        end
      end
      if (cmd_i.clr_sel) begin
        found_q <= 1'b0;
      end else if (rd_vld_q && rd_sel_q && hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // Statistics and wheel payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (cmd_i.clr_stats) begin
      best_q  <= '0;
      worst_q <= '1;
    end else if (rd_vld_q && !rd_sel_q) begin
      if (rd_data > best_q) begin
        best_q <= rd_data;
      end
      if (rd_data < worst_q) begin
        worst_q <= rd_data;
      end
    end
    if (cmd_i.clr_sel) begin
      frac_q   <= random_fraction_i;
      sum_q    <= '0;
      chosen_q <= '0;
    end else if (rd_vld_q && rd_sel_q) begin
      sum_q <= sum_nx;
      if (hit && !found_q) begin
        chosen_q <= rd_idx_q;
      end
    end
    if (cmd_i.mul) begin
      slice_q <= frac_q * total_q;
    end
  end

  rfs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(total_q),
    .divisor_i (walk_n),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stats) begin
      kind_q      <= rfs_pkg::KIND_STATS;
      sel_idx_q   <= '0;
      fit_idx_q   <= 8'(fidx_q);
      best_out_q  <= 32'(best_q);
      worst_out_q <= 32'(worst_q);
      total_out_q <= total_q;
      avg_out_q   <= quotient[31:0];
    end else if (cmd_i.emit_sel) begin
      kind_q      <= rfs_pkg::KIND_SELECT;
      sel_idx_q   <= 8'(chosen_q);
      fit_idx_q   <= '0;
      best_out_q  <= '0;
      worst_out_q <= '0;
      total_out_q <= '0;
      avg_out_q   <= '0;
    end
  end

  assign result_strobe_o   = strobe_q;
  assign result_kind_o     = kind_q;
  assign selected_index_o  = sel_idx_q;
  assign fittest_index_o   = fit_idx_q;
  assign best_fitness_o    = best_out_q;
  assign worst_fitness_o   = worst_out_q;
  assign total_fitness_o   = total_out_q;
  assign average_fitness_o = avg_out_q;

endmodule

// ===== sv/roulette_fitness_selector.sv =====
// Top level of the roulette fitness selector: configuration port and wiring.
// Depends on rfs_pkg, rfs_ctrl and rfs_dp.
`timescale 1ns / 1ps

// Items enter on start_i while busy_o is low. A write gives no result; busy_o
// stays low. Statistics and selection walk the first n table entries (n from
// population_size, 1..256), reading one entry per cycle from a single-port
// table. Statistics keeps busy_o high through the walk and a 40-step restoring
// divider for the average. Selection keeps busy_o high through a multiply state
// for the wheel slice and the walk. The result beat appears on result_strobe_o
// for one cycle right after busy_o falls; the receiver has no way to stall it,
// and a new item may be started in that same cycle. Unused fields of a beat
// read as zero.

module roulette_fitness_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  entry_index_i,
  input  logic [31:0] fitness_value_i,
  input  logic [15:0] random_fraction_i,
  output logic        result_strobe_o,
  output logic        result_kind_o,
  output logic [7:0]  selected_index_o,
  output logic [7:0]  fittest_index_o,
  output logic [31:0] best_fitness_o,
  output logic [31:0] worst_fitness_o,
  output logic [39:0] total_fitness_o,
  output logic [31:0] average_fitness_o
);

  logic [rfs_pkg::CFG_POP_BITS-1:0] pop_q;
  logic                             cfg_we;
  rfs_pkg::cmd_t                    cmd;
  rfs_pkg::status_t                 status;

  // Decode the register write on the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == rfs_pkg::REG_POP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= rfs_pkg::CFG_POP_BITS'(256);
    end else if (cfg_we) begin
      pop_q <= pwdata[rfs_pkg::CFG_POP_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == rfs_pkg::REG_POP) ? 32'(pop_q) : '0;

  rfs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .opcode_i(opcode_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  rfs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .pop_i            (pop_q),
    .entry_index_i    (entry_index_i),
    .fitness_value_i  (fitness_value_i),
    .random_fraction_i(random_fraction_i),
    .result_strobe_o  (result_strobe_o),
    .result_kind_o    (result_kind_o),
    .selected_index_o (selected_index_o),
    .fittest_index_o  (fittest_index_o),
    .best_fitness_o   (best_fitness_o),
    .worst_fitness_o  (worst_fitness_o),
    .total_fitness_o  (total_fitness_o),
    .average_fitness_o(average_fitness_o)
  );

  // A result beat always closes a busy period
  a_beat_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy_o))
    else $error("result beat without a preceding busy period");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a start");

endmodule

// ===== dv/roulette_fitness_selector_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for roulette_fitness_selector: table writes, statistics and wheel picks
// on the command port, population size set over APB. Depends on rfs_pkg and the block's RTL.

module roulette_fitness_selector_test;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [2:0] ADDR_POP      = 3'd0;
  localparam logic [2:0] ADDR_SPARE    = 3'd4;
  localparam int         ITEM_TARGET   = 1750;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 8;

  typedef struct packed {
    logic        kind;
    logic [7:0]  sel_idx;
    logic [7:0]  fit_idx;
    logic [31:0] best;
    logic [31:0] worst;
    logic [39:0] total;
    logic [31:0] average;
  } fitness_beat_t;

  // Mirror of the fitness table and the kept totals; predicts each result beat
  class selection_scoreboard;
    logic [31:0]   fitness_mem [rfs_pkg::MAX_POPULATION];
    logic [39:0]   kept_total;
    logic [7:0]    kept_fittest;
    logic [8:0]    pop_size;
    fitness_beat_t due_beats[$];
    int            mismatches;
    int            stats_beats;
    int            select_beats;

    function new();
      foreach (fitness_mem[i]) fitness_mem[i] = '0;
      kept_total   = '0;
      kept_fittest = '0;
      pop_size     = 9'd256;
      mismatches   = 0;
      stats_beats  = 0;
      select_beats = 0;
    endfunction

    // Clamp the register to the entries actually walked
    function int walk_count();
      int n;
      n = pop_size;
      if (n == 0) n = 1;
      if (n > rfs_pkg::MAX_POPULATION) n = rfs_pkg::MAX_POPULATION;
      return n;
    endfunction

    // Update the mirror for an accepted item and queue its result, if any
    function void note_item(logic [1:0] op, logic [7:0] idx, logic [31:0] fval,
                            logic [15:0] frac);
      fitness_beat_t beat;
      int            n;
      int            chosen;
      logic [31:0]   best;
      logic [31:0]   worst;
      logic [39:0]   total;
      logic [39:0]   run_sum;
      logic [55:0]   slice;
      n    = walk_count();
      beat = '0;
      case (op)
        rfs_pkg::OP_WRITE: begin
          fitness_mem[idx] = fval;
        end
        rfs_pkg::OP_STATS: begin
          best  = '0;
          worst = '1;
          total = '0;
          for (int i = 0; i < n; i++) begin
            if (fitness_mem[i] > best) begin
              best         = fitness_mem[i];
              kept_fittest = i[7:0];
            end
            if (fitness_mem[i] < worst) worst = fitness_mem[i];
            total = total + fitness_mem[i];
          end
          kept_total   = total;
          beat.kind    = rfs_pkg::KIND_STATS;
          beat.fit_idx = kept_fittest;
          beat.best    = best;
          beat.worst   = worst;
          beat.total   = total;
          beat.average = 32'(total / n);
          due_beats    = {due_beats, beat};
        end
        rfs_pkg::OP_SELECT: begin
          slice   = frac * kept_total;
          run_sum = '0;
          chosen  = 0;
          for (int i = 0; i < n; i++) begin
            run_sum = run_sum + fitness_mem[i];
            if ({run_sum, 16'h0000} >= slice) begin
              chosen = i;
              break;
            end
          end
          beat.kind    = rfs_pkg::KIND_SELECT;
          beat.sel_idx = chosen[7:0];
          due_beats    = {due_beats, beat};
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [39:0] want_v, logic [39:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    // Match a result beat against the oldest prediction
    function void check_result(fitness_beat_t got);
      fitness_beat_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected result beat, kind %0d", $time, got.kind);
        mismatches++;
        return;
      end
      want = due_beats.pop_front();
      if (want.kind == rfs_pkg::KIND_STATS) stats_beats++;
      else select_beats++;
      compare_field("result_kind", want.kind, got.kind);
      compare_field("selected_index", want.sel_idx, got.sel_idx);
      compare_field("fittest_index", want.fit_idx, got.fit_idx);
      compare_field("best_fitness", want.best, got.best);
      compare_field("worst_fitness", want.worst, got.worst);
      compare_field("total_fitness", want.total, got.total);
      compare_field("average_fitness", want.average, got.average);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  opcode_i;
  logic [7:0]  entry_index_i;
  logic [31:0] fitness_value_i;
  logic [15:0] random_fraction_i;
  logic        result_strobe_o;
  logic        result_kind_o;
  logic [7:0]  selected_index_o;
  logic [7:0]  fittest_index_o;
  logic [31:0] best_fitness_o;
  logic [31:0] worst_fitness_o;
  logic [39:0] total_fitness_o;
  logic [31:0] average_fitness_o;

  selection_scoreboard sb = new();
  int items_done;
  int write_count;
  int cfg_writes;
  int stall_cycles;
  bit calm;

  roulette_fitness_selector u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .opcode_i          (opcode_i),
    .entry_index_i     (entry_index_i),
    .fitness_value_i   (fitness_value_i),
    .random_fraction_i (random_fraction_i),
    .result_strobe_o   (result_strobe_o),
    .result_kind_o     (result_kind_o),
    .selected_index_o  (selected_index_o),
    .fittest_index_o   (fittest_index_o),
    .best_fitness_o    (best_fitness_o),
    .worst_fitness_o   (worst_fitness_o),
    .total_fitness_o   (total_fitness_o),
    .average_fitness_o (average_fitness_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Sample result beats mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      sb.check_result({result_kind_o, selected_index_o, fittest_index_o, best_fitness_o,
                       worst_fitness_o, total_fitness_o, average_fitness_o});
    end
  end

  // Abort when neither an item nor a result beat moves for too long
  always @(negedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_strobe_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d beats still due", $time, sb.due_beats.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_fitness();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(0, 32'h0000_FFFF);
      5, 6:    return '0;
      7:       return '1;
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [15:0] rand_fraction();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Mostly small populations; the clamped extremes now and then
  function automatic logic [8:0] pick_population();
    int r;
    r = $urandom_range(0, 19);
    if (r <= 12) return $urandom_range(1, 8);
    if (r <= 16) return $urandom_range(9, 64);
    if (r == 17) return $urandom_range(65, 300);
    if (r == 18) begin
      case ($urandom_range(0, 3))
        0:       return 9'd0;
        1:       return 9'd1;
        2:       return 9'd255;
        default: return 9'd256;
      endcase
    end
    return $urandom_range(257, 511);
  endfunction

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until accepted, then log it with the scoreboard
  task automatic send_item(int gap, logic [1:0] op, logic [7:0] idx, logic [31:0] fval,
                           logic [15:0] frac);
    bit taken;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i           <= 1'b1;
    opcode_i          <= op;
    entry_index_i     <= idx;
    fitness_value_i   <= fval;
    random_fraction_i <= frac;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_item(op, idx, fval, frac);
    if (op != OP_UNUSED) items_done++;
    if (op == rfs_pkg::OP_WRITE) write_count++;
  endtask

  // Drop start and wait until every predicted beat has arrived
  task automatic drain(int settle);
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.due_beats.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // One APB transfer; leaves psel high so a second transfer can follow directly
  task automatic apb_cycle(bit wr, logic [2:0] addr, logic [31:0] data,
                           output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (!pready);
    rd = prdata;
    @(posedge clk_i);
  endtask

  // Write a register and read population_size back
  task automatic set_register(logic [2:0] addr, logic [31:0] data);
    logic [31:0] back;
    apb_cycle(1'b1, addr, data, back);
    cfg_writes++;
    if (addr == ADDR_POP) sb.pop_size = data[8:0];
    apb_cycle(1'b0, ADDR_POP, '0, back);
    if (back !== {23'b0, sb.pop_size}) begin
      $display("%0t: population_size readback expected 0x%0h, got 0x%0h",
               $time, sb.pop_size, back);
      sb.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic directed_items();
    logic [31:0] v;
    // Fill the whole table; tie two maxima and plant a zero minimum
    for (int i = 0; i < rfs_pkg::MAX_POPULATION; i++) begin
      v = rand_fitness();
      if (i == 5 || i == 7) v = '1;
      if (i == 9) v = '0;
      send_item(0, rfs_pkg::OP_WRITE, i[7:0], v, $urandom);
    end
    // Pick before any statistics, an unknown opcode, then the full walk
    send_item(0, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'hFFFF);
    send_item(1, OP_UNUSED, $urandom, $urandom, $urandom);
    send_item(0, rfs_pkg::OP_STATS, $urandom, $urandom, $urandom);
    send_item(0, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'h0000);
    send_item(2, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'hFFFF);
    send_item(0, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'h8000);
    // Single-entry population
    drain(SETTLE_CYCLES);
    set_register(ADDR_POP, 32'd1);
    send_item(0, rfs_pkg::OP_STATS, $urandom, $urandom, $urandom);
    send_item(0, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'hFFFF);
    // No positive entry: zero total, fittest index held
    for (int i = 0; i < 4; i++) send_item(0, rfs_pkg::OP_WRITE, i[7:0], '0, $urandom);
    drain(SETTLE_CYCLES);
    set_register(ADDR_POP, 32'd0);
    send_item(0, rfs_pkg::OP_STATS, $urandom, $urandom, $urandom);
    send_item(0, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'hFFFF);
    drain(SETTLE_CYCLES);
    set_register(ADDR_POP, 32'd4);
    send_item(0, rfs_pkg::OP_STATS, $urandom, $urandom, $urandom);
    send_item(0, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'h1234);
    // Clamped size, then shrink the table under a stale total so the wheel is missed
    drain(SETTLE_CYCLES);
    set_register(ADDR_POP, 32'd511);
    send_item(0, rfs_pkg::OP_WRITE, 8'd2, '1, $urandom);
    send_item(0, rfs_pkg::OP_STATS, $urandom, $urandom, $urandom);
    send_item(0, rfs_pkg::OP_WRITE, 8'd5, '0, $urandom);
    send_item(0, rfs_pkg::OP_WRITE, 8'd7, '0, $urandom);
    send_item(0, rfs_pkg::OP_SELECT, $urandom, $urandom, 16'hFFFF);
    // Write outside the register map must leave the size alone
    drain(SETTLE_CYCLES);
    set_register(ADDR_SPARE, 32'h0000_0001);
    send_item(0, rfs_pkg::OP_STATS, $urandom, $urandom, $urandom);
  endtask

  // Bursts of writes, a statistics walk and a few picks; some bursts skip the walk
  task automatic random_phase();
    int n;
    n = sb.walk_count();
    repeat ($urandom_range(3, 10)) begin
      repeat ($urandom_range(0, 4)) begin
        send_item(idle_gap(), rfs_pkg::OP_WRITE,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1)
                                              : $urandom_range(0, 255),
                  rand_fitness(), $urandom);
      end
      if ($urandom_range(0, 9) != 0) begin
        send_item(idle_gap(), rfs_pkg::OP_STATS, $urandom, $urandom, $urandom);
      end
      repeat ($urandom_range(1, 5)) begin
        send_item(idle_gap(), rfs_pkg::OP_SELECT, $urandom, $urandom, rand_fraction());
      end
      if ($urandom_range(0, 19) == 0) begin
        send_item(idle_gap(), OP_UNUSED, $urandom, $urandom, $urandom);
      end
      if ($urandom_range(0, 19) == 0) drain(1);
    end
  endtask

  initial begin
    logic [31:0] back;
    logic [31:0] cfg;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    start_i           = 1'b0;
    opcode_i          = rfs_pkg::OP_WRITE;
    entry_index_i     = '0;
    fitness_value_i   = '0;
    random_fraction_i = '0;
    items_done        = 0;
    write_count       = 0;
    cfg_writes        = 0;
    stall_cycles      = 0;
    calm              = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of population_size
    apb_cycle(1'b0, ADDR_POP, '0, back);
    if (back !== 32'd256) begin
      $display("%0t: population_size reset expected 0x100, got 0x%0h", $time, back);
      sb.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);

    directed_items();

    while (items_done < ITEM_TARGET) begin
      drain(SETTLE_CYCLES);
      cfg       = $urandom;
      cfg[8:0]  = pick_population();
      set_register(ADDR_POP, cfg);
      if ($urandom_range(0, 7) == 0) set_register(ADDR_SPARE, $urandom);
      calm = ($urandom_range(0, 3) == 0);
      random_phase();
    end

    drain(60);
    if (sb.due_beats.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, sb.due_beats.size());
      sb.mismatches++;
    end
    $display("covered %0d table writes, %0d statistics and %0d selection beats",
             write_count, sb.stats_beats, sb.select_beats);
    $display("over %0d register writes, population sizes from clamped zero to 511",
             cfg_writes);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rfs_pkg.sv
sv/rfs_ram.sv
sv/rfs_div.sv
sv/rfs_ctrl.sv
sv/rfs_dp.sv
sv/roulette_fitness_selector.sv
dv/roulette_fitness_selector_test.sv
